// File: rtl/smq_pkg.sv
// smq_pkg: shared types and codes for the shared-buffer multi-queue core
// request/response payload structs, operation and status codes, control structs
// no dependencies
`default_nettype none

package smq_pkg;

   localparam int DATA_W = 32;
   localparam int QID_W  = 3;

   typedef enum logic [0:0] {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [QID_W-1:0]         queue_id;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
   } rsp_type;

   // free list commands
   typedef struct packed {
      logic pop;
      logic push;
   } fl_ctl_type;

   // queue table commands and lookup status
   typedef struct packed {
      logic enq;
      logic deq;
   } qt_ctl_type;

   typedef struct packed {
      logic valid;
      logic single;
   } qt_stat_type;

endpackage

`default_nettype wire

// File: rtl/smq_link_mem.sv
// smq_link_mem: link store, one write port and one registered read port
// depends on nothing but its parameter
`default_nettype none

module smq_link_mem #(
   parameter int NUM_ENTRIES = 64,
   localparam int EW = $clog2(NUM_ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [EW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [EW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [NUM_ENTRIES];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/smq_free_list.sv
// smq_free_list: free entry allocator, recycled stack in front of never-used entries
// keeps the top two links of the recycled stack; depends on smq_pkg and the link store
`default_nettype none

module smq_free_list import smq_pkg::*; #(
   parameter int NUM_ENTRIES = 64,
   localparam int EW = $clog2(NUM_ENTRIES),
   localparam int CW = $clog2(NUM_ENTRIES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  fl_ctl_type    ctl,
   input  logic [EW-1:0] push_idx,
   input  logic [EW-1:0] link_rd,
   output logic          avail,
   output logic [EW-1:0] pop_idx,
   output logic [EW-1:0] top_idx,
   output logic          rd_en,
   output logic [EW-1:0] rd_addr
);

   logic [CW-1:0] fresh_ff, fresh_in;
   logic [CW-1:0] rec_cnt_ff, rec_cnt_in;
   logic [EW-1:0] rec_head_ff, rec_head_in;
   logic [EW-1:0] rec_next_ff, rec_next_in;
   logic          pend_ff, pend_in;
   logic [EW-1:0] rec_next_eff;
   logic          rec_any;

   always_comb begin
      rec_any      = (rec_cnt_ff != '0);
      // link of the second stack entry arrives from the link store in the cycle after its read
      rec_next_eff = pend_ff ? link_rd : rec_next_ff;
      avail        = rec_any || (fresh_ff != CW'(NUM_ENTRIES));
      pop_idx      = rec_any ? rec_head_ff : fresh_ff[EW-1:0];
      top_idx      = rec_head_ff;

      fresh_in    = fresh_ff;
      rec_cnt_in  = rec_cnt_ff;
      rec_head_in = rec_head_ff;
      rec_next_in = rec_next_eff;
      pend_in     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = rec_next_eff;

      if (ctl.pop) begin
         if (rec_any) begin
            rec_head_in = rec_next_eff;
            rec_cnt_in  = rec_cnt_ff - CW'(1);
            rd_en       = (rec_cnt_ff > CW'(2));
            pend_in     = rd_en;
         end else begin
            fresh_in = fresh_ff + CW'(1);
         end
      end else if (ctl.push) begin
         rec_head_in = push_idx;
         rec_next_in = rec_head_ff;
         rec_cnt_in  = rec_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff   <= '0;
         rec_cnt_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         fresh_ff   <= fresh_in;
         rec_cnt_ff <= rec_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_head_ff <= rec_head_in;
      rec_next_ff <= rec_next_in;
   end

endmodule

`default_nettype wire

// File: rtl/smq_queue_table.sv
// smq_queue_table: per-queue head, tail, head successor and valid bit
// head successor is refilled from the link store in the cycle after its read; depends on smq_pkg
`default_nettype none

module smq_queue_table import smq_pkg::*; #(
   parameter int NUM_QUEUES  = 8,
   parameter int NUM_ENTRIES = 64,
   localparam int EW = $clog2(NUM_ENTRIES),
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  qt_ctl_type    ctl,
   input  logic [QW-1:0] qid,
   input  logic [EW-1:0] enq_idx,
   input  logic [EW-1:0] link_rd,
   output qt_stat_type   stat,
   output logic [EW-1:0] head,
   output logic [EW-1:0] tail,
   output logic          rd_en,
   output logic [EW-1:0] rd_addr
);

   logic [EW-1:0]         head_ff [NUM_QUEUES];
   logic [EW-1:0]         tail_ff [NUM_QUEUES];
   logic [EW-1:0]         next_ff [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] valid_ff;
   logic                  pend_ff, pend_in;
   logic [QW-1:0]         pend_qid_ff, pend_qid_in;

   logic          head_we, tail_we, next_we, valid_we, valid_in;
   logic [EW-1:0] head_in, tail_in, next_in;
   logic [EW-1:0] next_eff;

   always_comb begin
      head        = head_ff[qid];
      tail        = tail_ff[qid];
      next_eff    = (pend_ff && (pend_qid_ff == qid)) ? link_rd : next_ff[qid];
      stat.valid  = valid_ff[qid];
      stat.single = (head == tail);

      head_we     = 1'b0;
      tail_we     = 1'b0;
      next_we     = 1'b0;
      valid_we    = 1'b0;
      valid_in    = 1'b0;
      head_in     = enq_idx;
      tail_in     = enq_idx;
      next_in     = enq_idx;
      rd_en       = 1'b0;
      rd_addr     = next_eff;
      pend_in     = 1'b0;
      pend_qid_in = qid;

      if (ctl.enq) begin
         tail_we = 1'b1;
         if (!stat.valid) begin
            head_we  = 1'b1;
            valid_we = 1'b1;
            valid_in = 1'b1;
         end else if (stat.single) begin
            next_we = 1'b1;
         end
      end else if (ctl.deq) begin
         if (stat.single) begin
            valid_we = 1'b1;
         end else begin
            head_we = 1'b1;
            head_in = next_eff;
            // fetch the new head's successor unless it is the last entry
            rd_en   = (next_eff != tail);
            pend_in = rd_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (valid_we) begin
            valid_ff[qid] <= valid_in;
         end
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[qid] <= head_in;
      end
      if (tail_we) begin
         tail_ff[qid] <= tail_in;
      end
      if (pend_ff) begin
         next_ff[pend_qid_ff] <= link_rd;
      end
      if (next_we) begin
         next_ff[qid] <= next_in;
      end
      pend_qid_ff <= pend_qid_in;
   end

endmodule

`default_nettype wire

// File: rtl/shared_buffer_multi_queue_core.sv
// shared_buffer_multi_queue_core: several FIFO queues in one shared data store
// top level with request/response registers and data store; uses smq_pkg,
// smq_link_mem, smq_free_list and smq_queue_table
//
// Usage: drive req_data and raise start for one cycle per command; a command
// transfers at a rising edge where start is high and busy is low. busy never
// rises, so one enqueue or dequeue command can transfer every cycle, with any
// mix of queues and operations back to back.
// Each command gives exactly one response: rsp_valid is high for one cycle and
// rsp_data holds the status and, for a successful dequeue, the data. The
// response passes through the request register, then the data-store read
// register. The receiver cannot stall it.
// Pointer updates go through short logic into registers; the link of a new head
// entry comes back from the link store in the next cycle and is forwarded to a
// following command on the same queue or free list.
// Reset (synchronous, active high) empties all queues and frees all entries;
// no clearing pass over the stores is needed.
`default_nettype none

module shared_buffer_multi_queue_core import smq_pkg::*; #(
   parameter int NUM_QUEUES  = 8,
   parameter int NUM_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [8:0] NQ_LIMIT = 9'(NUM_QUEUES);

   logic                req_valid_ff;
   req_type             req_ff;
   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic                deq_hit_ff;
   logic [DATA_W-1:0]   data_rd_ff;
   logic [DATA_W-1:0]   data_mem [NUM_ENTRIES];

   logic          q_ok, is_enq, enq_ok, deq_ok;
   logic [QW-1:0] qid;
   fl_ctl_type    fl_ctl;
   qt_ctl_type    qt_ctl;
   qt_stat_type   qt_stat;
   logic          fl_avail, fl_rd_en, qt_rd_en;
   logic [EW-1:0] fl_pop_idx, fl_top_idx, fl_rd_addr;
   logic [EW-1:0] qt_head, qt_tail, qt_rd_addr;
   logic          lk_we, lk_rd_en;
   logic [EW-1:0] lk_wa, lk_wd, lk_rd_addr, lk_rd_data;

   assign busy = 1'b0;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      q_ok   = (9'(req_ff.queue_id) < NQ_LIMIT);
      qid    = QW'(req_ff.queue_id);
      is_enq = (req_ff.op == OP_ENQ);
      enq_ok = req_valid_ff && is_enq && q_ok && fl_avail;
      deq_ok = req_valid_ff && !is_enq && q_ok && qt_stat.valid;

      fl_ctl.pop  = enq_ok;
      fl_ctl.push = deq_ok;
      qt_ctl.enq  = enq_ok;
      qt_ctl.deq  = deq_ok;

      // append links the old tail to the new entry; removal links the entry to the free top
      lk_we = (enq_ok && qt_stat.valid) || deq_ok;
      lk_wa = deq_ok ? qt_head : qt_tail;
      lk_wd = deq_ok ? fl_top_idx : fl_pop_idx;

      lk_rd_en   = fl_rd_en || qt_rd_en;
      lk_rd_addr = fl_rd_en ? fl_rd_addr : qt_rd_addr;

      if (is_enq) begin
         status_in = enq_ok ? ST_OK : ST_FULL;
      end else begin
         status_in = deq_ok ? ST_OK : ST_EMPTY;
      end
   end

   smq_link_mem #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_wa),
      .wr_data (lk_wd),
      .rd_en   (lk_rd_en),
      .rd_addr (lk_rd_addr),
      .rd_data (lk_rd_data)
   );

   smq_free_list #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_free_list (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fl_ctl),
      .push_idx (qt_head),
      .link_rd  (lk_rd_data),
      .avail    (fl_avail),
      .pop_idx  (fl_pop_idx),
      .top_idx  (fl_top_idx),
      .rd_en    (fl_rd_en),
      .rd_addr  (fl_rd_addr)
   );

   smq_queue_table #(
      .NUM_QUEUES  (NUM_QUEUES),
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_queue_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qt_ctl),
      .qid     (qid),
      .enq_idx (fl_pop_idx),
      .link_rd (lk_rd_data),
      .stat    (qt_stat),
      .head    (qt_head),
      .tail    (qt_tail),
      .rd_en   (qt_rd_en),
      .rd_addr (qt_rd_addr)
   );

   // data store and response register
   always_ff @(posedge clock) begin
      if (enq_ok) begin
         data_mem[fl_pop_idx] <= req_ff.data_in;
      end
      if (deq_ok) begin
         data_rd_ff <= data_mem[qt_head];
      end
      status_ff  <= status_in;
      deq_hit_ff <= deq_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{data_out: (deq_hit_ff ? data_rd_ff : '0), status: status_ff};

`ifndef SYNTHESIS
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid_ff)
      else $error("response missing one cycle after a registered request");

   a_rsp_no_extra: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> !rsp_valid_ff)
      else $error("response without a registered request");

   a_link_rd_excl: assert property (@(posedge clock) disable iff (reset)
      !(fl_rd_en && qt_rd_en))
      else $error("free list and queue table both fetch a link");

   a_link_wr_alloc: assert property (@(posedge clock) disable iff (reset)
      (enq_ok && qt_stat.valid) |-> (qt_tail != fl_pop_idx))
      else $error("tail link written onto the entry being allocated");

   a_deq_ok_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> !deq_hit_ff)
      else $error("failed command returns dequeued data");
`endif

endmodule

`default_nettype wire
